### rtl/mlbf_pkg.sv
// Shared types and codes for the MAC learning bridge forwarder.
package mlbf_pkg;

  localparam int unsigned MacW = 48;
  localparam int unsigned IfW  = 16;

  localparam logic [1:0] KindBridge  = 2'd0;
  localparam logic [1:0] KindUnicast = 2'd1;
  localparam logic [1:0] KindFlood   = 2'd2;
  localparam logic [1:0] KindNone    = 2'd3;

  localparam logic [1:0] LearnKnown = 2'd0;
  localparam logic [1:0] LearnNew   = 2'd1;
  localparam logic [1:0] LearnFull  = 2'd2;
  localparam logic [1:0] LearnNa    = 2'd3;

  localparam logic [1:0] RegBridge = 2'd0;
  localparam logic [1:0] RegFloodA = 2'd1;
  localparam logic [1:0] RegFloodB = 2'd2;

  localparam logic FuncIngress = 1'b0;

  typedef enum logic [2:0] {
    StIdle,
    StRead,
    StCmp,
    StResult,
    StOut1,
    StOut2
  } mlbf_state_e;

  typedef struct packed {
    logic load_in;
    logic rd_en;
    logic inc_idx;
    logic make_first;
    logic make_second;
  } mlbf_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic match;
    logic two_results;
  } mlbf_sts_t;

endpackage

### rtl/mlbf_ctrl.sv
// Sequencer for table scan, learn and result delivery.
module mlbf_ctrl
  import mlbf_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  input  mlbf_sts_t sts_i,
  output mlbf_cmd_t cmd_o
);

  mlbf_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (in_valid_i) state_d = StRead;
      end
      StRead: begin
        if (sts_i.scan_done) state_d = StResult;
        else state_d = StCmp;
      end
      StCmp: begin
        if (sts_i.match) state_d = StResult;
        else state_d = StRead;
      end
      StResult: state_d = StOut1;
      StOut1: begin
        if (out_ready_i) state_d = sts_i.two_results ? StOut2 : StIdle;
      end
      StOut2: begin
        if (out_ready_i) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      StIdle: begin
        in_ready_o    = 1'b1;
        cmd_o.load_in = in_valid_i;
      end
      StRead:   cmd_o.rd_en = !sts_i.scan_done;
      StCmp:    cmd_o.inc_idx = !sts_i.match;
      StResult: cmd_o.make_first = 1'b1;
      StOut1: begin
        out_valid_o       = 1'b1;
        cmd_o.make_second = out_ready_i && sts_i.two_results;
      end
      StOut2:   out_valid_o = 1'b1;
      default:  cmd_o = '0;
    endcase
  end

endmodule

### rtl/mlbf_dpath.sv
// Datapath: configuration, request registers, MAC table and result register.
module mlbf_dpath
  import mlbf_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = 1024
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_valid_i,
  input  logic [1:0]       cfg_index_i,
  input  logic [IfW-1:0]   cfg_data_i,
  input  logic             func_i,
  input  logic [MacW-1:0]  mac_i,
  input  logic [IfW-1:0]   arrival_i,
  input  mlbf_cmd_t        cmd_i,
  output mlbf_sts_t        sts_o,
  output logic [IfW-1:0]   out_ifindex_o,
  output logic [1:0]       send_kind_o,
  output logic [1:0]       learn_status_o,
  output logic             last_o
);

  localparam int unsigned AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned CW = AW + 1;

  logic [IfW-1:0] bridge_q, flood_a_q, flood_b_q;
  logic           func_q;
  logic [MacW-1:0] mac_q;
  logic [IfW-1:0] arrival_q;
  logic [CW-1:0]  used_q, idx_q;
  logic           hit_q, two_q;
  logic [IfW-1:0] hit_port_q;
  logic [MacW+IfW-1:0] mem_q [TABLE_ENTRIES];
  logic [MacW+IfW-1:0] rd_q;
  logic [IfW-1:0] out_if_q;
  logic [1:0]     kind_q, status_q;
  logic           last_q;

  logic full, match, learn;
  logic [IfW-1:0] r_if;
  logic [1:0]     r_kind, r_status;
  logic           r_last, r_two;

  assign full  = (used_q == CW'(TABLE_ENTRIES));
  assign match = (rd_q[MacW-1:0] == mac_q);
  assign learn = cmd_i.make_first && (func_q == FuncIngress) && (bridge_q != '0)
                 && !hit_q && !full;

  assign sts_o.scan_done   = (idx_q == used_q);
  assign sts_o.match       = match;
  assign sts_o.two_results = two_q;

  always_comb begin
    r_if     = '0;
    r_kind   = KindNone;
    r_status = LearnNa;
    r_last   = 1'b1;
    r_two    = 1'b0;
    if (func_q == FuncIngress) begin
      if (bridge_q != '0) begin
        r_if     = bridge_q;
        r_kind   = KindBridge;
        r_status = hit_q ? LearnKnown : (full ? LearnFull : LearnNew);
      end
    end else if (hit_q) begin
      r_if   = hit_port_q;
      r_kind = KindUnicast;
    end else if (flood_a_q != '0) begin
      r_if   = flood_a_q;
      r_kind = KindFlood;
      if (flood_b_q != '0) begin
        r_last = 1'b0;
        r_two  = 1'b1;
      end
    end else if (flood_b_q != '0) begin
      r_if   = flood_b_q;
      r_kind = KindFlood;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bridge_q  <= '0;
      flood_a_q <= '0;
      flood_b_q <= '0;
      used_q    <= '0;
      idx_q     <= '0;
      hit_q     <= 1'b0;
      two_q     <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          RegBridge: bridge_q  <= cfg_data_i;
          RegFloodA: flood_a_q <= cfg_data_i;
          RegFloodB: flood_b_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.load_in) begin
        idx_q <= '0;
        hit_q <= 1'b0;
      end else if (cmd_i.inc_idx) begin
        idx_q <= idx_q + CW'(1);
      end else if (match && !cmd_i.inc_idx && sts_o.match && !sts_o.scan_done
                   && !cmd_i.rd_en && !cmd_i.make_first && !cmd_i.make_second
                   && !hit_q && idx_q != used_q) begin
        hit_q <= 1'b1;
      end
      if (learn) used_q <= used_q + CW'(1);
      if (cmd_i.make_first) two_q <= r_two;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      func_q    <= func_i;
      mac_q     <= mac_i;
      arrival_q <= arrival_i;
    end
    if (cmd_i.rd_en) rd_q <= mem_q[idx_q[AW-1:0]];
    if (learn) mem_q[used_q[AW-1:0]] <= {arrival_q, mac_q};
    if (!hit_q) hit_port_q <= rd_q[MacW+IfW-1:MacW];
    if (cmd_i.make_first) begin
      out_if_q <= r_if;
      kind_q   <= r_kind;
      status_q <= r_status;
      last_q   <= r_last;
    end else if (cmd_i.make_second) begin
      out_if_q <= flood_b_q;
      kind_q   <= KindFlood;
      status_q <= LearnNa;
      last_q   <= 1'b1;
    end
  end

  assign out_ifindex_o  = out_if_q;
  assign send_kind_o    = kind_q;
  assign learn_status_o = status_q;
  assign last_o         = last_q;

endmodule

### rtl/mac_learning_bridge_forwarder_top.sv
// Top level of the MAC learning bridge forwarder.
// Layer-2 learning bridge with a fully associative table of TABLE_ENTRIES MACs,
// filled in order and searched linearly through one memory read port. Each
// learned entry scanned before a hit (all of them on a miss) costs a read state
// and a compare state; results wait while the output is back-pressured. An
// egress miss with both flood ports set yields two results. Configuration
// writes are always taken.
module mac_learning_bridge_forwarder_top
  import mlbf_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // mac_addr[47:0], arrival_ifindex[63:48]
  input  logic        s_axis_tuser,   // func
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // out_ifindex[15:0]
  output logic [3:0]  m_axis_tuser,   // send_kind[1:0], learn_status[3:2]
  output logic        m_axis_tlast
);

  mlbf_cmd_t cmd;
  mlbf_sts_t sts;

  assign cfg_ready_o = 1'b1;

  mlbf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  mlbf_dpath #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .func_i         (s_axis_tuser),
    .mac_i          (s_axis_tdata[47:0]),
    .arrival_i      (s_axis_tdata[63:48]),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .out_ifindex_o  (m_axis_tdata),
    .send_kind_o    (m_axis_tuser[1:0]),
    .learn_status_o (m_axis_tuser[3:2]),
    .last_o         (m_axis_tlast)
  );

endmodule

### tb/tb_mac_learning_bridge_forwarder_top.sv
// Self-checking testbench for the MAC learning bridge forwarder top level.
module tb_mac_learning_bridge_forwarder_top;
  import mlbf_pkg::*;

  localparam int unsigned Entries = 1024;
  localparam logic FuncEgress = 1'b1;
  localparam logic [1:0] RegNone = 2'd3;

  typedef struct packed {
    logic [15:0] ifx;
    logic [1:0]  kind;
    logic [1:0]  status;
    logic        last;
  } fwd_res_t;

  class fwd_scoreboard;
    logic [15:0] bridge_if, flood_a, flood_b;
    logic [47:0] tbl_mac[Entries];
    logic [15:0] tbl_port[Entries];
    int unsigned used;
    fwd_res_t pending[$];
    int unsigned errors;

    function void reset_state();
      bridge_if = '0; flood_a = '0; flood_b = '0;
      used = 0; errors = 0;
      pending.delete();
    endfunction

    function void write_reg(logic [1:0] idx, logic [15:0] val);
      case (idx)
        RegBridge: bridge_if = val;
        RegFloodA: flood_a = val;
        RegFloodB: flood_b = val;
        default: ;
      endcase
    endfunction

    function int lookup(logic [47:0] mac);
      for (int i = 0; i < used; i++)
        if (tbl_mac[i] == mac) return i;
      return -1;
    endfunction

    function void note_request(logic func, logic [47:0] mac, logic [15:0] arr);
      int hit;
      hit = lookup(mac);
      if (func == FuncIngress) begin
        if (bridge_if == 0) begin
          pending.push_back('{16'd0, KindNone, LearnNa, 1'b1});
        end else if (hit >= 0) begin
          pending.push_back('{bridge_if, KindBridge, LearnKnown, 1'b1});
        end else if (used < Entries) begin
          tbl_mac[used] = mac;
          tbl_port[used] = arr;
          used++;
          pending.push_back('{bridge_if, KindBridge, LearnNew, 1'b1});
        end else begin
          pending.push_back('{bridge_if, KindBridge, LearnFull, 1'b1});
        end
      end else if (hit >= 0) begin
        pending.push_back('{tbl_port[hit], KindUnicast, LearnNa, 1'b1});
      end else if (flood_a != 0 && flood_b != 0) begin
        pending.push_back('{flood_a, KindFlood, LearnNa, 1'b0});
        pending.push_back('{flood_b, KindFlood, LearnNa, 1'b1});
      end else if (flood_a != 0) begin
        pending.push_back('{flood_a, KindFlood, LearnNa, 1'b1});
      end else if (flood_b != 0) begin
        pending.push_back('{flood_b, KindFlood, LearnNa, 1'b1});
      end else begin
        pending.push_back('{16'd0, KindNone, LearnNa, 1'b1});
      end
    endfunction

    function void check_result(fwd_res_t got);
      fwd_res_t want;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("Unexpected result %p", got);
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= 10) $display("Mismatch: expected %p, got %p", want, got);
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = '0;
  logic [15:0] cfg_data_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic [3:0]  m_axis_tuser;
  logic        m_axis_tlast;

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  fwd_scoreboard fwd_sb = new();
  logic [47:0] known_macs[$];

  always #4 clk_i = ~clk_i;

  mac_learning_bridge_forwarder_top #(.TABLE_ENTRIES(Entries)) dut (.*);

  // Receiver: random back-pressure and result checking.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready)
        fwd_sb.check_result('{m_axis_tdata, m_axis_tuser[1:0], m_axis_tuser[3:2],
                              m_axis_tlast});
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic write_cfg(logic [1:0] idx, logic [15:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    fwd_sb.write_reg(idx, val);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic send_request(logic func, logic [47:0] mac, logic [15:0] arr);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= func;
    s_axis_tdata  <= {arr, mac};
    do @(posedge clk_i); while (!s_axis_tready);
    fwd_sb.note_request(func, mac, arr);
    if (func == FuncIngress) known_macs.push_back(mac);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (fwd_sb.pending.size() != 0) @(posedge clk_i);
    // Scans of a nearly full table run long, so also wait out a full table scan.
    repeat (2 * Entries + 50) @(posedge clk_i);
  endtask

  task automatic apply_settings(logic [15:0] b, logic [15:0] fa, logic [15:0] fb);
    drain();
    write_cfg(RegBridge, b);
    write_cfg(RegFloodA, fa);
    write_cfg(RegFloodB, fb);
  endtask

  function automatic logic [47:0] pick_mac();
    if (known_macs.size() != 0 && $urandom_range(99) < 55)
      return known_macs[$urandom_range(known_macs.size() - 1)];
    return {$urandom_range(3) == 0 ? 16'hffff : 16'($urandom), 32'($urandom)};
  endfunction

  task automatic random_phase(int unsigned n);
    for (int i = 0; i < n; i++)
      send_request(logic'($urandom_range(1)), pick_mac(), 16'($urandom));
  endtask

  initial begin
    fwd_sb.reset_state();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: no bridge, no flood ports, extremes and ignored register.
    send_request(FuncIngress, 48'hffff_ffff_ffff, 16'hffff);
    send_request(FuncEgress, 48'h0, 16'h0);
    drain();
    write_cfg(RegNone, 16'h1234);
    write_cfg(RegBridge, 16'hffff);
    send_request(FuncIngress, 48'h0, 16'h0);            // learned on port zero
    send_request(FuncIngress, 48'h0, 16'h5555);         // already known
    send_request(FuncIngress, 48'hffff_ffff_ffff, 16'hffff);
    send_request(FuncIngress, 48'haaaa_aaaa_aaaa, 16'haaaa);
    send_request(FuncEgress, 48'h0, 16'hffff);          // unicast to zero
    send_request(FuncEgress, 48'hffff_ffff_ffff, 16'h0);
    send_request(FuncEgress, 48'h5555_5555_5555, 16'h0); // miss, nothing sent
    apply_settings(16'h0, 16'h1, 16'h0);
    send_request(FuncEgress, 48'h5555_5555_5555, 16'h0); // flood a only
    send_request(FuncEgress, 48'haaaa_aaaa_aaaa, 16'h0); // egress without bridge
    send_request(FuncIngress, 48'h1, 16'h1);
    apply_settings(16'h1, 16'h0, 16'hffff);
    send_request(FuncEgress, 48'h5555_5555_5555, 16'h0);
    apply_settings(16'h8000, 16'hffff, 16'h1);
    send_request(FuncEgress, 48'h5555_5555_5555, 16'h0);

    // Pause until every result is in, then random traffic in three idle modes.
    drain();
    send_idle_pct = 37; recv_idle_pct = 86;
    random_phase(300);
    apply_settings(16'($urandom_range(1, 65535)), 16'($urandom), 16'($urandom));
    send_idle_pct = 86; recv_idle_pct = 37;
    random_phase(300);
    apply_settings(16'($urandom_range(1, 65535)), 16'hffff, 16'h7);
    send_idle_pct = 0; recv_idle_pct = 0;
    random_phase(400);

    // Fill the table to reach the full case, then more traffic on a full table.
    for (int i = fwd_sb.used; i < Entries + 20; i++)
      send_request(FuncIngress, {16'hc0de, 32'(i)}, 16'($urandom));
    apply_settings(16'h0, 16'h0, 16'h0);
    random_phase(100);
    apply_settings(16'h4321, 16'h10, 16'h0);
    random_phase(100);
    drain();

    if (fwd_sb.errors == 0 && fwd_sb.pending.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #200_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
